### rtl/adsr_pkg.sv
package adsr_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int ENV_BITS = 16;
  localparam logic [ENV_BITS-1:0] FULL_SCALE = 16'h8000;

  localparam int CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ATTACK   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SUSTAIN  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NOTE_OFF = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE  = 3'd4;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          note_start;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [ENV_BITS-1:0]           envelope;
  } out_item_t;

endpackage

### rtl/adsr_muldiv.sv
module adsr_muldiv #(
  parameter int TIME_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [TIME_BITS-1:0]          x,
  input  logic [adsr_pkg::ENV_BITS-1:0] k,
  input  logic [TIME_BITS-1:0]          den,
  output logic                          done,
  output logic [adsr_pkg::ENV_BITS-1:0] quot
);

  localparam int EB = adsr_pkg::ENV_BITS;
  localparam int ACC_BITS = TIME_BITS + EB;
  localparam int STEP_BITS = $clog2(EB);
  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(EB - 1);

  logic                 busy;
  logic                 dividing;
  logic [STEP_BITS-1:0] cnt;
  logic [EB-1:0]        kreg;
  logic [TIME_BITS-1:0] xreg;
  logic [TIME_BITS-1:0] denreg;
  logic [ACC_BITS-1:0]  acc;
  logic [ACC_BITS-1:0]  acc_next;
  logic [TIME_BITS:0]   trial;
  logic [TIME_BITS:0]   trial_diff;
  logic                 fits;
  logic [TIME_BITS-1:0] rem;

  // The product x*k is built one multiplier bit a cycle, most significant
  // first. Restoring division by den then yields one quotient bit a cycle in
  // the low end of the same register, since x < den keeps the quotient
  // within ENV_BITS bits.
  always_comb begin
    trial = {acc[ACC_BITS-1:EB], acc[EB-1]};
    trial_diff = trial - {1'b0, denreg};
    fits = (trial >= {1'b0, denreg});
    rem = fits ? trial_diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
    if (dividing) begin
      acc_next = {rem, acc[EB-2:0], fits};
    end else begin
      acc_next = {acc[ACC_BITS-2:0], 1'b0}
                 + {{EB{1'b0}}, (kreg[EB-1] ? xreg : {TIME_BITS{1'b0}})};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      dividing <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        dividing <= 1'b0;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + STEP_BITS'(1);
        if (cnt == LAST_STEP) begin
          if (dividing) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            dividing <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      kreg <= k;
      xreg <= x;
      denreg <= den;
      acc <= '0;
    end else if (busy) begin
      kreg <= {kreg[EB-2:0], 1'b0};
      acc <= acc_next;
    end
  end

  assign quot = acc[EB-1:0];

endmodule

### rtl/adsr_envelope_gain.sv
// An accepted sample passes through the decode, setup, scaling, gain and finish
// states in that order; the block takes one item at a time.
// Scaling runs the bit-serial scaling divider (16 multiply steps and 16 divide
// steps), gain the bit-serial gain multiplier (16 steps); finish waits for a free output.
// Reset restores the register defaults, clears the sample counter and empties the
// output register.
module adsr_envelope_gain #(
  parameter int TIME_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  adsr_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output adsr_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [adsr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [((TIME_BITS > adsr_pkg::ENV_BITS) ? TIME_BITS : adsr_pkg::ENV_BITS)-1:0] cfg_data
);

  localparam int SB = adsr_pkg::SAMPLE_BITS;
  localparam int EB = adsr_pkg::ENV_BITS;
  localparam int COUNT_BITS = TIME_BITS + 2;
  localparam int PROD_BITS = SB + EB;
  localparam int STEP_BITS = $clog2(EB);
  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(EB - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [TIME_BITS-1:0] ATTACK_RST   = TIME_BITS'(441);
  localparam logic [TIME_BITS-1:0] DECAY_RST    = TIME_BITS'(4410);
  localparam logic [EB-1:0]        SUSTAIN_RST  = EB'(22938);
  localparam logic [TIME_BITS-1:0] NOTE_OFF_RST = TIME_BITS'(22050);
  localparam logic [TIME_BITS-1:0] RELEASE_RST  = TIME_BITS'(8820);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_SETUP  = 3'd2;
  localparam logic [2:0] ST_SCALE  = 3'd3;
  localparam logic [2:0] ST_AMP    = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  localparam logic [2:0] PH_ATTACK  = 3'd0;
  localparam logic [2:0] PH_DECAY   = 3'd1;
  localparam logic [2:0] PH_SUSTAIN = 3'd2;
  localparam logic [2:0] PH_RELEASE = 3'd3;
  localparam logic [2:0] PH_SILENT  = 3'd4;

  logic [TIME_BITS-1:0]  attack_samples;
  logic [TIME_BITS-1:0]  decay_samples;
  logic [EB-1:0]         sustain_level;
  logic [TIME_BITS-1:0]  note_off_samples;
  logic [TIME_BITS-1:0]  release_samples;
  logic [TIME_BITS:0]    decay_end;
  logic [TIME_BITS:0]    release_end;

  logic [2:0]            state;
  logic [COUNT_BITS-1:0] sample_count;
  logic [COUNT_BITS-1:0] cur_count;
  logic signed [SB-1:0]  sample;
  logic [2:0]            phase;
  logic [2:0]            phase_next;
  logic                  rising;
  logic [EB-1:0]         base;
  logic [EB-1:0]         base_next;
  logic [EB-1:0]         env;
  logic [EB-1:0]         env_next;
  logic [EB-1:0]         env_sh;
  logic signed [PROD_BITS-1:0] amp_acc;
  logic signed [PROD_BITS-1:0] amp_addend;
  logic [STEP_BITS-1:0]  amp_cnt;

  logic                  in_accept;
  logic                  out_free;
  logic [EB-1:0]         level;
  logic [COUNT_BITS-1:0] diff_a;
  logic [COUNT_BITS-1:0] diff_n;
  logic                  md_start;
  logic [TIME_BITS-1:0]  md_x;
  logic [EB-1:0]         md_k;
  logic [TIME_BITS-1:0]  md_den;
  logic                  md_done;
  logic [EB-1:0]         md_quot;

  assign in_stall = (state != ST_IDLE);
  assign in_accept = in_valid && (state == ST_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign md_start = (state == ST_SETUP);

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_samples <= ATTACK_RST;
      decay_samples <= DECAY_RST;
      sustain_level <= SUSTAIN_RST;
      note_off_samples <= NOTE_OFF_RST;
      release_samples <= RELEASE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        adsr_pkg::REG_ATTACK:   attack_samples <= cfg_data[TIME_BITS-1:0];
        adsr_pkg::REG_DECAY:    decay_samples <= cfg_data[TIME_BITS-1:0];
        adsr_pkg::REG_SUSTAIN:  sustain_level <= cfg_data[EB-1:0];
        adsr_pkg::REG_NOTE_OFF: note_off_samples <= cfg_data[TIME_BITS-1:0];
        adsr_pkg::REG_RELEASE:  release_samples <= cfg_data[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Phase boundaries are summed ahead of time so that decoding needs compares only.
  always_ff @(posedge clk) begin
    decay_end <= {1'b0, attack_samples} + {1'b0, decay_samples};
    release_end <= {1'b0, note_off_samples} + {1'b0, release_samples};
  end

  always_comb begin
    if (cur_count < {2'b00, attack_samples}) begin
      phase_next = PH_ATTACK;
    end else if (cur_count < {1'b0, decay_end}) begin
      phase_next = PH_DECAY;
    end else if (cur_count < {2'b00, note_off_samples}) begin
      phase_next = PH_SUSTAIN;
    end else if (cur_count < {1'b0, release_end}) begin
      phase_next = PH_RELEASE;
    end else begin
      phase_next = PH_SILENT;
    end
  end

  // Every phase is a base level minus a scaled ramp, except attack, which rises.
  always_comb begin
    level = (sustain_level > adsr_pkg::FULL_SCALE) ? adsr_pkg::FULL_SCALE : sustain_level;
    diff_a = cur_count - {2'b00, attack_samples};
    diff_n = cur_count - {2'b00, note_off_samples};
    case (phase)
      PH_ATTACK: begin
        md_x = cur_count[TIME_BITS-1:0];
        md_k = adsr_pkg::FULL_SCALE;
        md_den = attack_samples;
        base_next = '0;
      end
      PH_DECAY: begin
        md_x = diff_a[TIME_BITS-1:0];
        md_k = adsr_pkg::FULL_SCALE - level;
        md_den = decay_samples;
        base_next = adsr_pkg::FULL_SCALE;
      end
      PH_SUSTAIN: begin
        md_x = '0;
        md_k = '0;
        md_den = TIME_BITS'(1);
        base_next = level;
      end
      PH_RELEASE: begin
        md_x = diff_n[TIME_BITS-1:0];
        md_k = level;
        md_den = release_samples;
        base_next = level;
      end
      default: begin
        md_x = '0;
        md_k = '0;
        md_den = TIME_BITS'(1);
        base_next = '0;
      end
    endcase
    env_next = rising ? md_quot : (base - md_quot);
    amp_addend = env_sh[EB-1] ? PROD_BITS'(sample) : '0;
  end

  adsr_muldiv #(
    .TIME_BITS(TIME_BITS)
  ) u_muldiv (
    .clk  (clk),
    .rst  (rst),
    .start(md_start),
    .x    (md_x),
    .k    (md_k),
    .den  (md_den),
    .done (md_done),
    .quot (md_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sample_count <= '0;
      amp_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            state <= ST_DECODE;
            if (in_data.note_start) begin
              sample_count <= COUNT_BITS'(1);
            end else if (sample_count != COUNT_MAX) begin
              sample_count <= sample_count + COUNT_BITS'(1);
            end
          end
        end
        ST_DECODE: state <= ST_SETUP;
        ST_SETUP:  state <= ST_SCALE;
        ST_SCALE: begin
          if (md_done) begin
            state <= ST_AMP;
            amp_cnt <= '0;
          end
        end
        ST_AMP: begin
          amp_cnt <= amp_cnt + STEP_BITS'(1);
          if (amp_cnt == LAST_STEP) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur_count <= in_data.note_start ? '0 : sample_count;
      sample <= in_data.sample_in;
    end
    if (state == ST_DECODE) begin
      phase <= phase_next;
    end
    if (state == ST_SETUP) begin
      base <= base_next;
      rising <= (phase == PH_ATTACK);
    end
    if (state == ST_SCALE && md_done) begin
      env <= env_next;
      env_sh <= env_next;
      amp_acc <= '0;
    end
    if (state == ST_AMP) begin
      env_sh <= {env_sh[EB-2:0], 1'b0};
      amp_acc <= (amp_acc <<< 1) + amp_addend;
    end
    if (state == ST_FINISH && out_free) begin
      out_data.sample_out <= amp_acc[PROD_BITS-2:EB-1];
      out_data.envelope <= env;
    end
  end

`ifndef SYNTH
  a_env_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.envelope <= adsr_pkg::FULL_SCALE)
    else $error("envelope above full scale");

  a_done_in_scale: assert property (@(posedge clk) disable iff (rst)
    md_done |-> state == ST_SCALE)
    else $error("divider finished outside the scaling state");

  a_ramp_bound: assert property (@(posedge clk) disable iff (rst)
    (md_done && !rising) |-> md_quot <= base)
    else $error("ramp exceeds its base level");

  a_count_advances: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> sample_count != '0)
    else $error("sample counter did not advance");

  a_load_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("result presented outside the finish state");
`endif

endmodule

### tb/sv/tb_adsr_envelope_gain.sv
module tb_adsr_envelope_gain;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIME_BITS = 24;
  localparam int COUNT_BITS = TIME_BITS + 2;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [TIME_BITS-1:0] LEN_MAX = '1;
  localparam logic [TIME_BITS-1:0] LEVEL_FULL = TIME_BITS'(adsr_pkg::FULL_SCALE);

  typedef enum int {PH_ATTACK, PH_DECAY, PH_SUSTAIN, PH_RELEASE, PH_SILENT} phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  adsr_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  adsr_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [adsr_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [TIME_BITS-1:0] cfg_data = '0;

  // Envelope settings and note position as the block should hold them.
  logic [TIME_BITS-1:0] attack_len = TIME_BITS'(441);
  logic [TIME_BITS-1:0] decay_len = TIME_BITS'(4410);
  logic [15:0] sustain_raw = 16'd22938;
  logic [TIME_BITS-1:0] note_off_at = TIME_BITS'(22050);
  logic [TIME_BITS-1:0] release_len = TIME_BITS'(8820);
  logic [COUNT_BITS-1:0] sample_count = '0;

  adsr_pkg::out_item_t pending_out[$];
  adsr_pkg::out_item_t next_out;
  logic steady = 1'b0;
  int error_count = 0;
  int checked_count = 0;
  int sample_total = 0;
  int settings_count = 0;
  int cycle_count = 0;
  int phase_hits [5] = '{default: 0};
  logic [15:0] edge_samples [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};

  adsr_envelope_gain #(.TIME_BITS(TIME_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               pending_out.size());
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst || steady) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 36);
    end
  end

  task automatic flag_mismatch(input string msg);
    error_count++;
    if (error_count <= 100) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_out.size() == 0) begin
        flag_mismatch($sformatf("unexpected transaction out=%0d env=%0d",
                                $signed(out_data.sample_out), out_data.envelope));
      end else begin
        next_out = pending_out.pop_front();
        if (out_data.sample_out !== next_out.sample_out)
          flag_mismatch($sformatf("result %0d sample_out %0d, expected %0d", checked_count,
                                  $signed(out_data.sample_out), $signed(next_out.sample_out)));
        if (out_data.envelope !== next_out.envelope)
          flag_mismatch($sformatf("result %0d envelope %0d, expected %0d", checked_count,
                                  out_data.envelope, next_out.envelope));
        checked_count++;
      end
    end
  end

  function automatic logic [15:0] envelope_for(input logic [COUNT_BITS-1:0] s,
                                               output phase_t ph);
    longint unsigned sc, a, d, n, r, lvl, full;
    sc = 64'(s);
    a = 64'(attack_len);
    d = 64'(decay_len);
    n = 64'(note_off_at);
    r = 64'(release_len);
    full = 64'(adsr_pkg::FULL_SCALE);
    lvl = (sustain_raw > adsr_pkg::FULL_SCALE) ? full : 64'(sustain_raw);
    if (sc < a) begin
      ph = PH_ATTACK;
      return 16'(sc * full / a);
    end
    if (sc < a + d) begin
      ph = PH_DECAY;
      return 16'(full - (sc - a) * (full - lvl) / d);
    end
    if (sc < n) begin
      ph = PH_SUSTAIN;
      return 16'(lvl);
    end
    if (sc < n + r) begin
      ph = PH_RELEASE;
      return 16'(lvl - lvl * (sc - n) / r);
    end
    ph = PH_SILENT;
    return 16'h0000;
  endfunction

  task automatic take_sample(input adsr_pkg::in_item_t item);
    logic [COUNT_BITS-1:0] s;
    logic [15:0] env;
    phase_t ph;
    adsr_pkg::out_item_t res;
    longint prod;
    s = item.note_start ? '0 : sample_count;
    env = envelope_for(s, ph);
    phase_hits[ph]++;
    prod = longint'($signed(item.sample_in)) * longint'(env);
    prod = prod >>> 15;
    res.sample_out = prod[15:0];
    res.envelope = env;
    pending_out.push_back(res);
    sample_count = (&s) ? s : s + 1'b1;
    sample_total++;
  endtask

  task automatic send_sample(input logic [15:0] smp, input logic start);
    adsr_pkg::in_item_t item;
    item.sample_in = smp;
    item.note_start = start;
    @(negedge clk);
    if (!steady && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    take_sample(item);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [adsr_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [TIME_BITS-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      adsr_pkg::REG_ATTACK: attack_len = data;
      adsr_pkg::REG_DECAY: decay_len = data;
      adsr_pkg::REG_SUSTAIN: sustain_raw = data[15:0];
      adsr_pkg::REG_NOTE_OFF: note_off_at = data;
      adsr_pkg::REG_RELEASE: release_len = data;
      default: ;
    endcase
  endtask

  task automatic set_envelope(input logic [TIME_BITS-1:0] a, input logic [TIME_BITS-1:0] d,
                              input logic [TIME_BITS-1:0] lvl,
                              input logic [TIME_BITS-1:0] n, input logic [TIME_BITS-1:0] r);
    wait_idle();
    write_reg(adsr_pkg::REG_ATTACK, a);
    write_reg(adsr_pkg::REG_DECAY, d);
    write_reg(adsr_pkg::REG_SUSTAIN, lvl);
    write_reg(adsr_pkg::REG_NOTE_OFF, n);
    write_reg(adsr_pkg::REG_RELEASE, r);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  function automatic logic [TIME_BITS-1:0] pick_len(input int unsigned hi);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 85) return TIME_BITS'($urandom_range(0, hi));
    if (roll < 92) return LEN_MAX;
    return TIME_BITS'($urandom());
  endfunction

  function automatic logic [TIME_BITS-1:0] pick_level();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return LEVEL_FULL;
    if (roll < 30) return TIME_BITS'($urandom_range(32769, 65535));
    return TIME_BITS'($urandom_range(0, 32768));
  endfunction

  function automatic logic [15:0] random_sample();
    if ($urandom_range(99) < 10) return edge_samples[$urandom_range(4)];
    return 16'($urandom());
  endfunction

  task automatic test_defaults();
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h8000, 1'b0);
  endtask

  task automatic test_phase_walk();
    set_envelope(24'd2, 24'd2, 24'd16384, 24'd6, 24'd2);
    for (int k = 0; k < 10; k++) send_sample(edge_samples[k % 5], k == 0);
  endtask

  task automatic test_zero_lengths();
    set_envelope(24'd0, 24'd0, LEVEL_FULL, 24'd1, 24'd0);
    for (int k = 0; k < 3; k++) send_sample(edge_samples[k % 5], k == 0);
  endtask

  task automatic test_sustain_clamp();
    set_envelope(24'd1, 24'd0, 24'h00FFFF, 24'd3, 24'd2);
    for (int k = 0; k < 3; k++) send_sample(16'h8000, k == 0);
    wait_idle();
    write_reg(adsr_pkg::REG_SUSTAIN, 24'hFF0123);
    @(negedge clk);
    cfg_we <= 1'b0;
    send_sample(16'h7FFF, 1'b0);
  endtask

  // Note-off falls inside the attack, so release takes over straight from the decay end.
  task automatic test_early_note_off();
    set_envelope(24'd2, 24'd3, 24'd8192, 24'd1, 24'd6);
    for (int k = 0; k < 8; k++) send_sample(edge_samples[(k + 1) % 5], k == 0);
  endtask

  task automatic test_long_lengths();
    set_envelope(LEN_MAX, LEN_MAX, LEVEL_FULL, LEN_MAX, LEN_MAX);
    send_sample(16'h7FFF, 1'b1);
    set_envelope(24'd1, LEN_MAX, 24'd0, 24'd0, LEN_MAX);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7FFF, 1'b0);
  endtask

  task automatic test_unknown_index();
    wait_idle();
    for (int idx = int'(adsr_pkg::REG_RELEASE) + 1; idx < (1 << adsr_pkg::CFG_INDEX_BITS);
         idx++)
      write_reg(idx[adsr_pkg::CFG_INDEX_BITS-1:0], TIME_BITS'($urandom()));
    @(negedge clk);
    cfg_we <= 1'b0;
    send_sample(16'h7FFF, 1'b0);
  endtask

  task automatic test_random_notes();
    int unsigned sent;
    int unsigned note_len;
    for (int round = 0; round < 8; round++) begin
      steady = (round == 3 || round == 4);
      set_envelope(pick_len(12), pick_len(12), pick_level(), pick_len(40), pick_len(20));
      sent = 0;
      while (sent < 100) begin
        note_len = $urandom_range(1, 90);
        for (int k = 0; k < note_len && sent < 100; k++) begin
          send_sample(random_sample(), k == 0 || $urandom_range(99) < 2);
          sent++;
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_defaults();
    test_phase_walk();
    test_zero_lengths();
    test_sustain_clamp();
    test_early_note_off();
    test_long_lengths();
    test_unknown_index();
    test_random_notes();
    wait_idle();
    repeat (60) @(posedge clk);
    $display("Sent %0d samples under %0d envelope settings; %0d results compared.",
             sample_total, settings_count, checked_count);
    $display("Phases hit: attack %0d, decay %0d, sustain %0d, release %0d, silence %0d.",
             phase_hits[PH_ATTACK], phase_hits[PH_DECAY], phase_hits[PH_SUSTAIN],
             phase_hits[PH_RELEASE], phase_hits[PH_SILENT]);
    if (error_count == 0 && pending_out.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
